@@ design/swrsi_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swrsi_pkg
// Shared widths, constants, register indexes and types of the sliding window
// RSI block.
// ----------------------------------------------------------------------------
package swrsi_pkg;

	localparam int PRICE_BITS = 32;
	localparam int MAX_WINDOW = 64;
	localparam int WL_BITS    = $clog2(MAX_WINDOW + 1);
	localparam int SUM_BITS   = PRICE_BITS + $clog2(MAX_WINDOW);
	localparam int THR_BITS   = 8;
	localparam int RSI_BITS   = 15;
	localparam int STEP_BITS  = $clog2(RSI_BITS);
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [RSI_BITS-1:0] RSI_SCALE = RSI_BITS'(25600);
	localparam logic [WL_BITS-1:0]  WL_MIN    = WL_BITS'(2);
	localparam logic [WL_BITS-1:0]  WL_MAX    = WL_BITS'(MAX_WINDOW);
	localparam logic [WL_BITS-1:0]  WL_RESET  = WL_BITS'(14);
	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(1);

	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic REG_THRESHOLD     = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_REM,
		S_ADD,
		S_CHECK,
		S_DIV,
		S_DONE
	} state_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ design/swrsi_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swrsi_cell
// One price cell of the window chain: takes the new price when it is the
// window's newest slot, otherwise takes its neighbor's price on each shift.
// ----------------------------------------------------------------------------
module swrsi_cell import swrsi_pkg::*; (
	input  wire logic                  clk,
	input  wire cell_ctrl_t            ctrl,
	input  wire logic [PRICE_BITS-1:0] new_price,
	input  wire logic [PRICE_BITS-1:0] next_price,
	output logic      [PRICE_BITS-1:0] held_price
);

	logic [PRICE_BITS-1:0] price_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			price_q <= ctrl.load ? new_price : next_price;
		end
	end

	assign held_price = price_q;

endmodule
`default_nettype wire

@@ design/swrsi_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swrsi_div
// Serial restoring divider: floor(num * RSI_SCALE / den), taking each
// quotient bit in a shift phase followed by an add phase.
// ----------------------------------------------------------------------------
module swrsi_div import swrsi_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [SUM_BITS-1:0] num,
	input  wire logic [SUM_BITS:0]   den,
	output logic                     done,
	output logic      [RSI_BITS-1:0] quot
);

	logic                 busy_q;
	logic                 done_q;
	logic                 phase_q;
	logic [STEP_BITS-1:0] step_q;
	logic [SUM_BITS-1:0]  num_q;
	logic [SUM_BITS:0]    den_q;
	logic [SUM_BITS:0]    rem_q;
	logic [RSI_BITS-1:0]  quot_q;

	logic [SUM_BITS+1:0] shifted;
	logic [SUM_BITS+1:0] summed;
	logic [SUM_BITS+1:0] den_ext;
	logic [SUM_BITS+1:0] shifted_sub;
	logic [SUM_BITS+1:0] summed_sub;
	logic                shift_ge;
	logic                sum_ge;

	always_comb begin
		den_ext     = {1'b0, den_q};
		shifted     = {rem_q, 1'b0};
		summed      = {1'b0, rem_q} + {2'b00, num_q};
		shifted_sub = shifted - den_ext;
		summed_sub  = summed - den_ext;
		shift_ge    = shifted >= den_ext;
		sum_ge      = summed >= den_ext;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			phase_q <= 1'b0;
			step_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				phase_q <= 1'b0;
				step_q  <= STEP_BITS'(RSI_BITS - 1);
			end else if (busy_q) begin
				phase_q <= ~phase_q;
				if (phase_q) begin
					if (step_q == '0) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end else begin
						step_q <= step_q - 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= num;
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			if (!phase_q) begin
				rem_q  <= shift_ge ? shifted_sub[SUM_BITS:0] : shifted[SUM_BITS:0];
				quot_q <= {quot_q[RSI_BITS-2:0], shift_ge};
			end else if (RSI_SCALE[step_q]) begin
				rem_q  <= sum_ge ? summed_sub[SUM_BITS:0] : summed[SUM_BITS:0];
				quot_q <= quot_q + RSI_BITS'(sum_ge);
			end
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule
`default_nettype wire

@@ design/sliding_window_rsi.sv @@
`default_nettype none
// Flow: a price passes through S_REM, S_ADD and S_CHECK, then a division or a
// threshold decides the result; no rsi while the window fills.
// Prices are taken one at a time: price_ready is high only in S_IDLE, and a
// division runs the serial divider over the 15 quotient bits.
// Reset: asynchronous, clears control, sums, fill count and registers to
// their defaults; the price cells are refilled after each window restart.
// ----------------------------------------------------------------------------
// sliding_window_rsi
// Simple-average RSI over a sliding window of prices held in a chain of cells.
// ----------------------------------------------------------------------------
module sliding_window_rsi import swrsi_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [PRICE_BITS-1:0] price,
	input  wire logic                  price_valid,
	output logic                       price_ready,
	output logic      [RSI_BITS-1:0]   rsi,
	output logic                       rsi_valid,
	input  wire logic                  rsi_ready,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [ADDR_BITS-1:0]  paddr,
	input  wire logic [DATA_BITS-1:0]  pwdata,
	output logic      [DATA_BITS-1:0]  prdata,
	output logic                       pready
);

	state_t state_q, state_d;

	logic [WL_BITS-1:0]  wl_q;
	logic [THR_BITS-1:0] thr_q;
	logic [WL_BITS-1:0]  seen_q;
	logic [SUM_BITS-1:0] gain_q;
	logic [SUM_BITS-1:0] loss_q;
	logic                rsi_valid_q;
	logic [RSI_BITS-1:0] rsi_q;
	logic [RSI_BITS-1:0] result_q;

	logic [PRICE_BITS-1:0] last_price_q;
	logic [PRICE_BITS-1:0] rem_mag_q;
	logic                  rem_gain_q;
	logic                  rem_en_q;
	logic [PRICE_BITS-1:0] add_mag_q;
	logic                  add_gain_q;
	logic                  add_en_q;

	logic                  in_txn;
	logic                  cfg_wr;
	logic [WL_BITS-1:0]    wl_wr;
	logic                  div_start;
	logic                  div_done;
	logic [RSI_BITS-1:0]   div_quot;
	logic                  out_load;
	logic                  below_gain;
	logic                  below_loss;
	logic                  window_full;
	logic [PRICE_BITS-1:0] cell_price [MAX_WINDOW];
	logic [PRICE_BITS-1:0] oldest;
	logic [PRICE_BITS-1:0] second;

	assign in_txn = price_valid && price_ready;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// window length write saturates to the legal range
	always_comb begin
		wl_wr = pwdata[WL_BITS-1:0];
		if (wl_wr < WL_MIN) begin
			wl_wr = WL_MIN;
		end else if (wl_wr > WL_MAX) begin
			wl_wr = WL_MAX;
		end
	end

	always_comb begin
		case (paddr[2])
			REG_WINDOW_LENGTH: prdata = DATA_BITS'(wl_q);
			REG_THRESHOLD:     prdata = DATA_BITS'(thr_q);
			default:           prdata = '0;
		endcase
	end

	// price chain, newest price enters at slot window_length-1, oldest at slot 0
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		cell_ctrl_t cctrl;
		assign cctrl.shift = in_txn;
		assign cctrl.load  = (wl_q == WL_BITS'(i + 1));
		swrsi_cell u_cell (
			.clk        (clk),
			.ctrl       (cctrl),
			.new_price  (price),
			.next_price (cell_price[(i == MAX_WINDOW - 1) ? i : i + 1]),
			.held_price (cell_price[i])
		);
	end

	assign oldest      = cell_price[0];
	assign second      = cell_price[1];
	assign window_full = seen_q >= wl_q;

	assign below_gain = gain_q < SUM_BITS'(thr_q);
	assign below_loss = loss_q < SUM_BITS'(thr_q);

	swrsi_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (gain_q),
		.den    ({1'b0, gain_q} + {1'b0, loss_q}),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		price_ready = 1'b0;
		div_start   = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			S_IDLE: begin
				price_ready = 1'b1;
				if (price_valid) begin
					state_d = S_REM;
				end
			end
			S_REM: begin
				state_d = S_ADD;
			end
			S_ADD: begin
				state_d = S_CHECK;
			end
			S_CHECK: begin
				if (!window_full) begin
					state_d = S_IDLE;
				end else if (below_gain || below_loss ||
				             (gain_q == '0 && loss_q == '0)) begin
					state_d = S_DONE;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!rsi_valid_q || rsi_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q        <= WL_RESET;
			thr_q       <= THR_RESET;
			seen_q      <= '0;
			gain_q      <= '0;
			loss_q      <= '0;
			rsi_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_WINDOW_LENGTH: begin
						wl_q   <= wl_wr;
						seen_q <= '0;
						gain_q <= '0;
						loss_q <= '0;
					end
					REG_THRESHOLD: begin
						thr_q <= pwdata[THR_BITS-1:0];
					end
					default: begin
					end
				endcase
			end
			if (in_txn && !window_full) begin
				seen_q <= seen_q + 1'b1;
			end
			if (state_q == S_REM && rem_en_q) begin
				if (rem_gain_q) begin
					gain_q <= gain_q - SUM_BITS'(rem_mag_q);
				end else begin
					loss_q <= loss_q - SUM_BITS'(rem_mag_q);
				end
			end
			if (state_q == S_ADD && add_en_q) begin
				if (add_gain_q) begin
					gain_q <= gain_q + SUM_BITS'(add_mag_q);
				end else begin
					loss_q <= loss_q + SUM_BITS'(add_mag_q);
				end
			end
			if (out_load) begin
				rsi_valid_q <= 1'b1;
			end else if (rsi_ready) begin
				rsi_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_txn) begin
			last_price_q <= price;
			rem_en_q     <= window_full;
			rem_gain_q   <= second > oldest;
			rem_mag_q    <= (second > oldest) ? (second - oldest) : (oldest - second);
			add_en_q     <= seen_q != '0;
			add_gain_q   <= price > last_price_q;
			add_mag_q    <= (price > last_price_q) ? (price - last_price_q)
			                                       : (last_price_q - price);
		end
		if (state_q == S_CHECK) begin
			result_q <= (!below_gain && below_loss) ? RSI_SCALE : '0;
		end
		if (state_q == S_DIV && div_done) begin
			result_q <= div_quot;
		end
		if (out_load) begin
			rsi_q <= result_q;
		end
	end

	assign rsi       = rsi_q;
	assign rsi_valid = rsi_valid_q;

endmodule
`default_nettype wire

@@ design/swrsi_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// swrsi_checker
// Port-level checks of the sliding window RSI block, bound to the top level.
// ----------------------------------------------------------------------------
module swrsi_checker import swrsi_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  price_valid,
	input wire logic                  price_ready,
	input wire logic [RSI_BITS-1:0]   rsi,
	input wire logic                  rsi_valid,
	input wire logic                  rsi_ready,
	input wire logic                  psel,
	input wire logic                  pready
);

	// stalled result transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsi_valid && !rsi_ready |=> rsi_valid && $stable(rsi))
		else $error("rsi changed while stalled");

	a_rsi_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsi_valid |-> rsi <= RSI_SCALE)
		else $error("rsi above full scale");

	// one price at a time
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		price_valid && price_ready |=> !price_ready)
		else $error("price accepted while busy");

	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		price_valid && price_ready |=> !$rose(rsi_valid))
		else $error("result appeared right after price");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("pready low");

endmodule

bind sliding_window_rsi swrsi_checker u_swrsi_checker (.*);
`default_nettype wire

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sliding window RSI block. Prices go in through
// a valid/ready channel and the window length and zero-sum threshold are set
// over the APB port between phases. A scoreboard tracks the price window and
// the gain and loss sums, predicts every rsi transaction and checks the
// results in order while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
	import swrsi_pkg::*;

	localparam int HEAD_BITS = $clog2(MAX_WINDOW);
	localparam int SETTLE    = 12;
	localparam int STALL_PCT = 27;
	localparam int LIMIT     = 3000;
	localparam int N_PRICES  = 1600;

	typedef enum int {PM_FULL, PM_WALK, PM_FLAT, PM_TREND, PM_EXTREME} price_mode_t;

	class rsi_predictor;
		logic [PRICE_BITS-1:0] ring [MAX_WINDOW];
		logic [HEAD_BITS-1:0]  head;
		logic [WL_BITS-1:0]    seen;
		logic [WL_BITS-1:0]    wlen;
		logic [THR_BITS-1:0]   thr;
		logic [SUM_BITS-1:0]   gain;
		logic [SUM_BITS-1:0]   loss;
		logic [RSI_BITS-1:0]   rsi_due [$];
		int checked;
		int bad;
		int n_zero;
		int n_full;

		function new();
			head = '0;
			seen = '0;
			gain = '0;
			loss = '0;
			wlen = WL_RESET;
			thr = THR_RESET;
			checked = 0;
			bad = 0;
			n_zero = 0;
			n_full = 0;
		endfunction

		function void configure(logic idx, logic [DATA_BITS-1:0] data);
			logic [WL_BITS-1:0] v;
			if (idx == REG_WINDOW_LENGTH) begin
				v = data[WL_BITS-1:0];
				if (v < WL_MIN) v = WL_MIN;
				if (v > WL_MAX) v = WL_MAX;
				wlen = v;
				seen = '0;
				gain = '0;
				loss = '0;
			end else begin
				thr = data[THR_BITS-1:0];
			end
		endfunction

		function void tally(logic [PRICE_BITS-1:0] prev, logic [PRICE_BITS-1:0] nxt,
				bit take_out);
			if (nxt > prev) begin
				if (take_out) gain = gain - SUM_BITS'(nxt - prev);
				else gain = gain + SUM_BITS'(nxt - prev);
			end else begin
				if (take_out) loss = loss - SUM_BITS'(prev - nxt);
				else loss = loss + SUM_BITS'(prev - nxt);
			end
		endfunction

		function void take_price(logic [PRICE_BITS-1:0] p);
			logic [HEAD_BITS-1:0] oldest;
			logic [63:0]          scaled;
			logic [RSI_BITS-1:0]  r;
			if (seen >= wlen) begin
				oldest = head - wlen[HEAD_BITS-1:0];
				tally(ring[oldest], ring[oldest + 1'b1], 1'b1);
				tally(ring[head - 1'b1], p, 1'b0);
			end else begin
				if (seen != 0) tally(ring[head - 1'b1], p, 1'b0);
				seen = seen + 1'b1;
			end
			ring[head] = p;
			head = head + 1'b1;
			if (seen < wlen) return;
			if (gain < SUM_BITS'(thr)) begin
				r = '0;
			end else if (loss < SUM_BITS'(thr)) begin
				r = RSI_SCALE;
			end else if (gain + loss == 0) begin
				r = '0;
			end else begin
				scaled = 64'(gain) * 64'(RSI_SCALE);
				r = RSI_BITS'(scaled / 64'(gain + loss));
			end
			rsi_due.push_back(r);
		endfunction

		function void check_rsi(logic [RSI_BITS-1:0] got);
			logic [RSI_BITS-1:0] want;
			if (rsi_due.size() == 0) begin
				bad++;
				if (bad <= 10) $display("error: rsi %0d arrived with nothing pending", got);
				return;
			end
			want = rsi_due.pop_front();
			checked++;
			if (got === want) begin
				if (want == 0) n_zero++;
				if (want == RSI_SCALE) n_full++;
			end else begin
				bad++;
				if (bad <= 10) $display("error: rsi expected %0d got %0d", want, got);
			end
		endfunction

		function int pending();
			return rsi_due.size();
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic [PRICE_BITS-1:0] price;
	logic                  price_valid;
	logic                  price_ready;
	logic [RSI_BITS-1:0]   rsi;
	logic                  rsi_valid;
	logic                  rsi_ready = 1'b0;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [ADDR_BITS-1:0]  paddr;
	logic [DATA_BITS-1:0]  pwdata;
	logic [DATA_BITS-1:0]  prdata;
	logic                  pready;

	rsi_predictor          sb = new();
	bit                    quiet = 1'b0;
	bit                    trend_up;
	int                    walk_span;
	logic [PRICE_BITS-1:0] last_price;
	int                    prices_sent = 0;
	int                    settings_used = 0;
	int                    idle_cycles = 0;

	sliding_window_rsi u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.price       (price),
		.price_valid (price_valid),
		.price_ready (price_ready),
		.rsi         (rsi),
		.rsi_valid   (rsi_valid),
		.rsi_ready   (rsi_ready),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		rsi_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= STALL_PCT);
	end

	always @(posedge clk) begin
		if (arst_n && rsi_valid && rsi_ready) sb.check_rsi(rsi);
	end

	always @(posedge clk) begin
		if ((price_valid && price_ready) || (rsi_valid && rsi_ready) ||
				(psel && penable && pwrite && pready) || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= LIMIT) begin
			$display("timeout: no transaction for %0d cycles", LIMIT);
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic push_price(input logic [PRICE_BITS-1:0] p);
		int k;
		k = 0;
		while (!quiet && $urandom_range(0, 99) < STALL_PCT) k++;
		if (k > 0) begin
			price_valid <= 1'b0;
			repeat (k) @(posedge clk);
		end
		price <= p;
		price_valid <= 1'b1;
		@(posedge clk);
		while (!price_ready) @(posedge clk);
		sb.take_price(p);
		prices_sent++;
	endtask

	task automatic drain_results(input int settle);
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	task automatic apb_write(input logic idx, input logic [DATA_BITS-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({idx, 2'b00});
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.configure(idx, data);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [PRICE_BITS-1:0] next_price(price_mode_t mode,
			logic [PRICE_BITS-1:0] prev);
		longint v;
		int     step;
		v = longint'(prev);
		case (mode)
			PM_FULL: begin
				return $urandom();
			end
			PM_WALK: begin
				step = int'($urandom_range(0, 2 * walk_span)) - walk_span;
				v = v + step;
			end
			PM_FLAT: begin
				if ($urandom_range(0, 9) == 0) v = v + (int'($urandom_range(0, 6)) - 3);
			end
			PM_TREND: begin
				step = int'($urandom_range(0, 400));
				if ($urandom_range(0, 19) == 0) v = trend_up ? v - step : v + step;
				else v = trend_up ? v + step : v - step;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return '1;
					2: return PRICE_BITS'(1);
					3: return {{(PRICE_BITS-1){1'b1}}, 1'b0};
					default: return {1'b1, {(PRICE_BITS-1){1'b0}}};
				endcase
			end
		endcase
		if (v < 0) v = 0;
		if (v > longint'({PRICE_BITS{1'b1}})) v = longint'({PRICE_BITS{1'b1}});
		return PRICE_BITS'(v);
	endfunction

	task automatic run_prices(input int count, input price_mode_t mode);
		logic [PRICE_BITS-1:0] p;
		for (int i = 0; i < count; i++) begin
			p = next_price(mode, last_price);
			last_price = p;
			push_price(p);
			if ($urandom_range(0, 99) == 0) begin
				price_valid <= 1'b0;
				drain_results(1);
			end
		end
		price_valid <= 1'b0;
	endtask

	initial begin
		int                    phase;
		int                    count;
		bit                    only_thr;
		logic [WL_BITS-1:0]    wl_val;
		logic [THR_BITS-1:0]   thr_val;
		logic [DATA_BITS-1:0]  data;

		arst_n <= 1'b0;
		price <= '0;
		price_valid <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: rising prices fill the window, then flat
		for (int i = 0; i < 16; i++) push_price(PRICE_BITS'(100 + (i < 14 ? i : 13)));
		price_valid <= 1'b0;
		drain_results(SETTLE);

		// window length below range, zero threshold, full-scale swings
		apb_write(REG_WINDOW_LENGTH, '0);
		apb_write(REG_THRESHOLD, '0);
		settings_used++;
		push_price('0);
		push_price('0);
		push_price('1);
		push_price('0);
		price_valid <= 1'b0;
		drain_results(SETTLE);

		// ignored upper data bits, top threshold
		apb_write(REG_WINDOW_LENGTH, 32'hFFFF_FF83);
		apb_write(REG_THRESHOLD, 32'h0000_01FF);
		settings_used++;
		push_price(PRICE_BITS'(1000));
		push_price(PRICE_BITS'(1300));
		push_price(PRICE_BITS'(1000));
		push_price(PRICE_BITS'(1000));
		price_valid <= 1'b0;
		drain_results(SETTLE);

		phase = 0;
		last_price = $urandom();
		while (prices_sent < N_PRICES) begin
			only_thr = (phase > 1) && ($urandom_range(0, 3) == 0);
			if (phase == 0) begin
				apb_write(REG_WINDOW_LENGTH, 32'h0000_007F);
			end else if (!only_thr) begin
				case ($urandom_range(0, 7))
					0: begin
						case ($urandom_range(0, 5))
							0: wl_val = 7'd0;
							1: wl_val = 7'd1;
							2: wl_val = WL_MIN;
							3: wl_val = WL_MAX;
							4: wl_val = WL_MAX + 1'b1;
							default: wl_val = 7'd127;
						endcase
					end
					1, 2, 3: wl_val = WL_BITS'($urandom_range(2, 8));
					default: wl_val = WL_BITS'($urandom_range(2, MAX_WINDOW));
				endcase
				data = $urandom_range(0, 1) ? ($urandom() & 32'hFFFF_FF80) : '0;
				apb_write(REG_WINDOW_LENGTH, data | DATA_BITS'(wl_val));
			end
			case ($urandom_range(0, 5))
				0: thr_val = '0;
				1: thr_val = THR_BITS'(1);
				2: thr_val = '1;
				default: thr_val = THR_BITS'($urandom_range(0, 255));
			endcase
			data = $urandom_range(0, 1) ? ($urandom() & 32'hFFFF_FF00) : '0;
			apb_write(REG_THRESHOLD, data | DATA_BITS'(thr_val));
			settings_used++;

			case ($urandom_range(0, 3))
				0: walk_span = 3;
				1: walk_span = 40;
				2: walk_span = 300;
				default: walk_span = 100000;
			endcase
			trend_up = $urandom_range(0, 1);
			case ($urandom_range(0, 3))
				0: last_price = PRICE_BITS'($urandom_range(0, 1000));
				1: last_price = '1 - PRICE_BITS'($urandom_range(0, 1000));
				default: last_price = $urandom();
			endcase

			count = int'(sb.wlen) + int'($urandom_range(4, 60));
			if (phase == 4) begin
				quiet = 1'b1;
				run_prices(200, PM_WALK);
				quiet = 1'b0;
			end else if (phase == 0) begin
				run_prices(count, PM_FULL);
			end else begin
				run_prices(count, price_mode_t'($urandom_range(0, 4)));
			end
			drain_results(SETTLE);
			phase++;
		end

		drain_results(40);
		$display("sent %0d prices over %0d register settings, checked %0d rsi values",
			prices_sent, settings_used, sb.checked);
		$display("results at zero: %0d, at full scale: %0d", sb.n_zero, sb.n_full);
		if (sb.pending() != 0)
			$display("error: %0d rsi values never arrived", sb.pending());
		if (sb.bad == 0 && sb.pending() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches", sb.bad);
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
